### rtl/mkd_pkg.sv
// Package for the Morse key decoder: codes, register map, letter table and lookup.
package mkd_pkg;

    // Field and register widths
    localparam int TICK_W       = 16;
    localparam int SYM_BITS_W   = 8;
    localparam int SYM_LEN_W    = 4;
    localparam int LETTER_W     = 5;
    localparam int KIND_W       = 2;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;
    localparam int LETTER_COUNT = 26;

    // Default symbol limit and register reset values
    localparam int SYMBOL_MAX_DEF = 8;
    localparam logic [TICK_W-1:0] DASH_TICKS_RST = 16'd100;
    localparam logic [TICK_W-1:0] DOT_TICKS_RST  = 16'd50;
    localparam logic [TICK_W-1:0] GAP_TICKS_RST  = 16'd100;
    localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;

    // Request type codes
    typedef enum logic
    {
        REQ_TICK = 1'b0,
        REQ_KEY  = 1'b1
    } req_kind_t;

    // Event kind codes
    typedef enum logic [KIND_W-1:0]
    {
        EV_DOT     = 2'd0,
        EV_DASH    = 2'd1,
        EV_LETTER  = 2'd2,
        EV_UNKNOWN = 2'd3
    } event_kind_t;

    // Register indexes (paddr word address)
    typedef enum logic [1:0]
    {
        REG_DASH_TICKS = 2'd0,
        REG_DOT_TICKS  = 2'd1,
        REG_GAP_TICKS  = 2'd2,
        REG_NONE       = 2'd3
    } reg_index_t;

    // Letter codes: bit i is symbol i, 1 = dash
    localparam logic [SYM_BITS_W-1:0] LETTER_BITS [LETTER_COUNT] = '{
        8'h02, 8'h01, 8'h05, 8'h01, 8'h00, 8'h04, 8'h03, 8'h00, 8'h00,
        8'h0E, 8'h05, 8'h02, 8'h03, 8'h01, 8'h07, 8'h06, 8'h0B, 8'h02,
        8'h00, 8'h01, 8'h04, 8'h08, 8'h06, 8'h09, 8'h0D, 8'h03
    };
    localparam logic [SYM_LEN_W-1:0] LETTER_LEN [LETTER_COUNT] = '{
        4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2,
        4'd4, 4'd3, 4'd4, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3,
        4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
    };

    // Lookup result
    typedef struct packed
    {
        logic                found;
        logic [LETTER_W-1:0] index;
    } letter_hit_t;

    // Find the first letter whose code and length match
    function automatic letter_hit_t find_letter(
        input logic [SYM_BITS_W-1:0] bits,
        input logic [SYM_LEN_W-1:0]  len
    );
        letter_hit_t hit;
        hit.found = 1'b0;
        hit.index = '0;
        for (int i = LETTER_COUNT - 1; i >= 0; i--)
        begin
            if (LETTER_LEN[i] == len && LETTER_BITS[i] == bits)
            begin
                hit.found = 1'b1;
                hit.index = LETTER_W'(i);
            end
        end
        return hit;
    endfunction

endpackage

### rtl/morse_key_decoder.sv
// Morse key decoder top level: tick counter, symbol store, letter lookup, APB registers.
//
//  channel   direction  handshake            payload
//  in        request    in_valid/in_ready    req_type, key_released
//  out       result     out_valid/out_ready  event_kind, letter_index
//  apb       config     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One request per cycle: each accepted request updates the counter and the
// symbol store and, when it causes a result, loads the result register in the
// same edge. A new request is taken while a result waits, as long as that
// result is being taken in the same cycle. Reset clears the counter, the
// symbol store and the result valid flag and loads the register defaults.
module morse_key_decoder #(
    parameter int SYMBOL_MAX = mkd_pkg::SYMBOL_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic                           key_released,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mkd_pkg::KIND_W-1:0]     event_kind,
    output logic [mkd_pkg::LETTER_W-1:0]   letter_index,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mkd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mkd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mkd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mkd_pkg::*;

    localparam logic [SYM_LEN_W-1:0] SYM_LIMIT = SYM_LEN_W'(SYMBOL_MAX);

    logic [TICK_W-1:0]     dash_ticks_reg, dot_ticks_reg, gap_ticks_reg;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [SYM_BITS_W-1:0] sym_bits_reg, sym_bits_next;
    logic [SYM_LEN_W-1:0]  sym_len_reg, sym_len_next;
    logic                  out_valid_reg;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [LETTER_W-1:0]   letter_reg, letter_next;
    logic                  emit;
    logic                  accept;
    logic                  cfg_write;
    reg_index_t            reg_sel;
    letter_hit_t           hit;

    assign in_ready     = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign letter_index = letter_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;
    assign reg_sel      = reg_index_t'(paddr[3:2]);
    assign hit          = find_letter(sym_bits_reg, sym_len_reg);

    // Decode register reads
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_DASH_TICKS: prdata = APB_DATA_W'(dash_ticks_reg);
            REG_DOT_TICKS:  prdata = APB_DATA_W'(dot_ticks_reg);
            REG_GAP_TICKS:  prdata = APB_DATA_W'(gap_ticks_reg);
            default:        prdata = '0;
        endcase
    end

    // Work out the next state and result for one request
    always_comb
    begin
        tick_count_next = tick_count_reg;
        sym_bits_next   = sym_bits_reg;
        sym_len_next    = sym_len_reg;
        emit            = 1'b0;
        kind_next       = EV_DOT;
        letter_next     = '0;
        if (req_type == REQ_TICK)
        begin
            // advance the saturating tick counter
            if (tick_count_reg != TICK_MAX)
                tick_count_next = tick_count_reg + 1'b1;
        end
        else if (key_released)
        begin
            // append a dash or a dot on a long enough release
            if (tick_count_reg > dash_ticks_reg || tick_count_reg > dot_ticks_reg)
            begin
                emit            = 1'b1;
                tick_count_next = '0;
                kind_next       = (tick_count_reg > dash_ticks_reg) ? EV_DASH : EV_DOT;
                if (sym_len_reg < SYM_LIMIT)
                begin
                    if (kind_next == EV_DASH && sym_len_reg < 4'(SYM_BITS_W))
                        sym_bits_next[sym_len_reg[2:0]] = 1'b1;
                    sym_len_next = sym_len_reg + 1'b1;
                end
            end
        end
        else if (tick_count_reg > gap_ticks_reg)
        begin
            // end the letter: look it up and drop the store
            emit            = 1'b1;
            tick_count_next = '0;
            sym_bits_next   = '0;
            sym_len_next    = '0;
            if (hit.found)
            begin
                kind_next   = EV_LETTER;
                letter_next = hit.index;
            end
            else
            begin
                kind_next = EV_UNKNOWN;
            end
        end
    end

    // Hold registers, state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_ticks_reg <= DASH_TICKS_RST;
            dot_ticks_reg  <= DOT_TICKS_RST;
            gap_ticks_reg  <= GAP_TICKS_RST;
            tick_count_reg <= '0;
            sym_bits_reg   <= '0;
            sym_len_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_sel)
                    REG_DASH_TICKS: dash_ticks_reg <= pwdata[TICK_W-1:0];
                    REG_DOT_TICKS:  dot_ticks_reg  <= pwdata[TICK_W-1:0];
                    REG_GAP_TICKS:  gap_ticks_reg  <= pwdata[TICK_W-1:0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                tick_count_reg <= tick_count_next;
                sym_bits_reg   <= sym_bits_next;
                sym_len_reg    <= sym_len_next;
                out_valid_reg  <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg   <= kind_next;
            letter_reg <= letter_next;
        end
    end

endmodule

### sim/morse_key_decoder_test.sv
// Testbench for the Morse key decoder: directed and random keying checked by a scoreboard.
module morse_key_decoder_test;
    import mkd_pkg::*;

    localparam int   SETTLE_CYCLES   = 8;
    localparam int   HOLD_OFF_CYCLES = 150;
    localparam int   PHASE_COUNT     = 12;
    localparam int   PHASE_REQUESTS  = 45;
    localparam int   LONG_TICKS      = 120;
    localparam int   HOLD_OFF_PHASE  = 8;
    localparam logic KEY_UP          = 1'b1;
    localparam logic KEY_DOWN        = 1'b0;

    typedef struct packed
    {
        event_kind_t         kind;
        logic [LETTER_W-1:0] letter;
    } key_event_t;

    // Scoreboard: tracks keying state and holds the decoder events still owed
    class morse_scoreboard;
        logic [TICK_W-1:0]     dash_limit;
        logic [TICK_W-1:0]     dot_limit;
        logic [TICK_W-1:0]     gap_limit;
        logic [TICK_W-1:0]     ticks;
        logic [SYM_BITS_W-1:0] sym_bits;
        logic [SYM_LEN_W-1:0]  sym_len;
        key_event_t            awaited[$];
        string                 codes[LETTER_COUNT];
        int                    errors;
        int                    symbols;
        int                    letters;
        int                    unknowns;

        function new();
            codes = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                      ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                      "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."};
            dash_limit = DASH_TICKS_RST;
            dot_limit  = DOT_TICKS_RST;
            gap_limit  = GAP_TICKS_RST;
            ticks      = '0;
            sym_bits   = '0;
            sym_len    = '0;
            errors     = 0;
            symbols    = 0;
            letters    = 0;
            unknowns   = 0;
        endfunction

        function void set_limit(reg_index_t r, logic [TICK_W-1:0] value);
            case (r)
                REG_DASH_TICKS: dash_limit = value;
                REG_DOT_TICKS:  dot_limit  = value;
                REG_GAP_TICKS:  gap_limit  = value;
                default: ;
            endcase
        endfunction

        function logic [TICK_W-1:0] limit_of(reg_index_t r);
            case (r)
                REG_DASH_TICKS: return dash_limit;
                REG_DOT_TICKS:  return dot_limit;
                REG_GAP_TICKS:  return gap_limit;
                default:        return '0;
            endcase
        endfunction

        // Store one symbol; the length stops at the symbol limit
        function void add_symbol(bit dash);
            if (sym_len < SYMBOL_MAX_DEF)
            begin
                if (dash && sym_len < SYM_BITS_W)
                    sym_bits[sym_len[2:0]] = 1'b1;
                sym_len = sym_len + 1'b1;
            end
            ticks = '0;
        endfunction

        // Match the collected string against the letter codes, -1 when none fits
        function int lookup();
            logic [SYM_BITS_W-1:0] bits;
            for (int i = 0; i < LETTER_COUNT; i++)
            begin
                bits = '0;
                for (int k = 0; k < codes[i].len(); k++)
                begin
                    if (codes[i][k] == "-")
                        bits[k] = 1'b1;
                end
                if (codes[i].len() == sym_len && bits == sym_bits)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(logic rtype, logic released);
            key_event_t ev;
            int         hit;
            ev.kind   = EV_DOT;
            ev.letter = '0;
            if (rtype == REQ_TICK)
            begin
                if (ticks != TICK_MAX)
                    ticks = ticks + 1'b1;
            end
            else if (released)
            begin
                // dash wins whenever both thresholds are passed
                if (ticks > dash_limit)
                begin
                    add_symbol(1'b1);
                    ev.kind = EV_DASH;
                    awaited.push_back(ev);
                end
                else if (ticks > dot_limit)
                begin
                    add_symbol(1'b0);
                    ev.kind = EV_DOT;
                    awaited.push_back(ev);
                end
            end
            else if (ticks > gap_limit)
            begin
                hit = lookup();
                if (hit >= 0)
                begin
                    ev.kind   = EV_LETTER;
                    ev.letter = LETTER_W'(hit);
                end
                else
                    ev.kind = EV_UNKNOWN;
                awaited.push_back(ev);
                ticks    = '0;
                sym_bits = '0;
                sym_len  = '0;
            end
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [LETTER_W-1:0] letter);
            key_event_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d letter %0d",
                         $time, kind, letter);
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind)
            begin
                errors++;
                $display("%0t: event_kind mismatch, expected %0d actual %0d",
                         $time, want.kind, kind);
            end
            if (letter !== want.letter)
            begin
                errors++;
                $display("%0t: letter_index mismatch, expected %0d actual %0d",
                         $time, want.letter, letter);
            end
            case (want.kind)
                EV_LETTER:  letters++;
                EV_UNKNOWN: unknowns++;
                default:    symbols++;
            endcase
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic                  req_type     = 1'b0;
    logic                  key_released = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [KIND_W-1:0]     event_kind;
    logic [LETTER_W-1:0]   letter_index;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    morse_scoreboard board;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              requests_sent  = 0;
    bit              holding_off    = 1'b0;
    event            hold_off_ev;

    morse_key_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .key_released (key_released),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .letter_index (letter_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 clk = ~clk;

    // Watch both channels at each edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(event_kind, letter_index);
            if (in_valid && in_ready)
                board.note_request(req_type, key_released);
        end
    end

    // Drive the result side: random stalls, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holding_off || !rst_n)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Count out the long hold-off of the result side
    always @(hold_off_ev)
    begin
        holding_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holding_off = 1'b0;
    end

    // Offer one request and hold it until accepted
    task automatic send_req(input logic rtype, input logic released);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rtype;
        key_released <= released;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Timer ticks carry a random key level that the block must ignore
    task automatic send_ticks(input int count);
        repeat (count)
            send_req(REQ_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_symbol(input int hold);
        send_ticks(hold);
        send_req(REQ_KEY, KEY_UP);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 5))
            send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Key one letter with random symbols against the current thresholds
    task automatic send_letter();
        int                nsym;
        int                hold;
        int                pick;
        logic [TICK_W-1:0] d;
        logic [TICK_W-1:0] t;
        logic [TICK_W-1:0] g;
        d    = board.dash_limit;
        t    = board.dot_limit;
        g    = board.gap_limit;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            nsym = 0;
        else if (pick < 85)
            nsym = $urandom_range(1, 4);
        else
            nsym = $urandom_range(5, 10);
        // a press after a long gap closes the previous letter
        send_ticks(g + 1 + $urandom_range(0, 2));
        send_req(REQ_KEY, KEY_DOWN);
        for (int i = 0; i < nsym; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                hold = $urandom_range(0, (d < t) ? d : t);
            else if (pick < 55 || t >= d)
                hold = d + 1 + $urandom_range(0, 2);
            else
                hold = $urandom_range(t + 1, d);
            send_symbol(hold);
            if (i < nsym - 1)
            begin
                send_ticks($urandom_range(0, g));
                send_req(REQ_KEY, KEY_DOWN);
            end
        end
    endtask

    // Drop valid and wait until every owed result has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_limit(input reg_index_t r);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {r, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {{(APB_DATA_W - TICK_W){1'b0}}, board.limit_of(r)})
        begin
            board.errors++;
            $display("%0t: register %0d readback, expected %0d actual %0d",
                     $time, r, board.limit_of(r), prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_limit(input reg_index_t r, input logic [TICK_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {{(APB_DATA_W - TICK_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_limit(r, value);
        @(posedge clk);
        check_limit(r);
    endtask

    task automatic configure(input logic [TICK_W-1:0] d, input logic [TICK_W-1:0] t,
                             input logic [TICK_W-1:0] g);
        write_limit(REG_DASH_TICKS, d);
        write_limit(REG_DOT_TICKS, t);
        write_limit(REG_GAP_TICKS, g);
    endtask

    initial
    begin
        #2_000_000;
        $display("morse_key_decoder verification failed");
        $finish;
    end

    initial
    begin
        int phase;
        int phase_start;
        board = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_limit(REG_DASH_TICKS);
        check_limit(REG_DOT_TICKS);
        check_limit(REG_GAP_TICKS);

        // Reset thresholds: a short press, then a dot
        send_req(REQ_KEY, KEY_DOWN);
        send_symbol(60);
        // Let the counter run; full-scale thresholds are never passed
        send_ticks(LONG_TICKS);
        settle();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(REQ_KEY, KEY_UP);
        send_req(REQ_KEY, KEY_DOWN);
        settle();
        write_limit(REG_DASH_TICKS, 16'd100);
        send_req(REQ_KEY, KEY_UP);
        settle();
        // Zero letter gap: one tick closes the dot-dash string as A
        configure(16'd3, 16'd1, 16'd0);
        send_req(REQ_TICK, KEY_UP);
        send_req(REQ_KEY, KEY_DOWN);
        settle();
        // Short release and short press change nothing; then an empty letter
        write_limit(REG_GAP_TICKS, 16'd4);
        send_req(REQ_TICK, KEY_UP);
        send_req(REQ_KEY, KEY_UP);
        send_req(REQ_KEY, KEY_DOWN);
        send_ticks(4);
        send_req(REQ_KEY, KEY_DOWN);
        // J as dot dash dash dash
        send_symbol(2);
        repeat (3)
        begin
            send_req(REQ_KEY, KEY_DOWN);
            send_symbol(4);
        end
        send_ticks(5);
        send_req(REQ_KEY, KEY_DOWN);
        // Overlong string: nine symbols, still reported, decodes unknown
        repeat (9)
        begin
            send_req(REQ_KEY, KEY_DOWN);
            send_symbol(2 + 2 * $urandom_range(0, 1));
        end
        send_ticks(5);
        send_req(REQ_KEY, KEY_DOWN);
        settle();
        // Dash threshold below dot threshold: dash still wins
        configure(16'd1, 16'd5, 16'd4);
        send_symbol(3);
        send_req(REQ_KEY, KEY_DOWN);
        send_symbol(7);
        send_ticks(5);
        send_req(REQ_KEY, KEY_DOWN);

        // Random keying over several threshold sets and idling modes
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            case (phase)
                4:       configure(16'd0, 16'd0, 16'd0);
                9:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                                   16'($urandom_range(0, 8)));
            endcase
            if (phase == HOLD_OFF_PHASE)
                -> hold_off_ev;
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                if (board.gap_limit > 16 || board.dash_limit > 16 || $urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_letter();
            end
        end
        settle();

        $display("Run covered %0d requests in %0d random phases plus directed keying,",
                 requests_sent, PHASE_COUNT);
        $display("  with %0d dots or dashes, %0d letters and %0d unknown strings checked.",
                 board.symbols, board.letters, board.unknowns);
        if (board.errors == 0)
            $display("morse_key_decoder verification clean");
        else
            $display("morse_key_decoder verification failed");
        $finish;
    end
endmodule

### files.f
rtl/mkd_pkg.sv
rtl/morse_key_decoder.sv
sim/morse_key_decoder_test.sv
